>>> design/oale_pkg.sv
// Package for the ordered array list engine.
// Holds field widths, request and status codes and the cell command codes.
// No dependencies; every other file of the block imports it.
package oale_pkg;

   localparam int REQ_TYPE_W = 3;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 5;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 5;

   typedef logic [REQ_TYPE_W-1:0] op_type;
   typedef logic [STATUS_W-1:0]   status_type;
   typedef logic [1:0]            cell_cmd_type;

   localparam op_type OP_APPEND    = 3'd0;
   localparam op_type OP_POP       = 3'd1;
   localparam op_type OP_INSERT    = 3'd2;
   localparam op_type OP_DEL_FIRST = 3'd3;
   localparam op_type OP_DEL_ALL   = 3'd4;
   localparam op_type OP_CLEAR     = 3'd5;
   localparam op_type OP_READ      = 3'd6;

   localparam status_type STAT_OK       = 3'd0;
   localparam status_type STAT_FULL     = 3'd1;
   localparam status_type STAT_EMPTY    = 3'd2;
   localparam status_type STAT_NOTFOUND = 3'd3;
   localparam status_type STAT_BADPOS   = 3'd4;

   // Cell commands: keep, take the broadcast word, take the lower neighbor
   // (shift toward the tail), take the upper neighbor (shift toward the head).
   localparam cell_cmd_type CELL_HOLD = 2'd0;
   localparam cell_cmd_type CELL_LOAD = 2'd1;
   localparam cell_cmd_type CELL_UP   = 2'd2;
   localparam cell_cmd_type CELL_DOWN = 2'd3;

endpackage

>>> design/oale_channels.sv
// Request and response channel interfaces of the ordered array list engine.
// Depends on oale_pkg for the field widths.
interface oale_req_if import oale_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [REQ_TYPE_W-1:0]     req_type;
   logic signed [VALUE_W-1:0] value;
   logic [POS_W-1:0]          position;

   modport source (output valid, req_type, value, position, input ready);
   modport sink (input valid, req_type, value, position, output ready);
endinterface

interface oale_rsp_if import oale_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] data;
   logic [COUNT_W-1:0]        count;
   logic [COUNT_W-1:0]        removed;

   modport source (output valid, status, data, count, removed, input ready);
   modport sink (input valid, status, data, count, removed, output ready);
endinterface

>>> design/oale_cell.sv
// One storage cell of the list chain: holds one entry.
// Depends on oale_pkg for the cell command codes.
module oale_cell import oale_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  cell_cmd_type          cmd,
   input  logic [DATA_WIDTH-1:0] load_data,
   input  logic [DATA_WIDTH-1:0] below_data,
   input  logic [DATA_WIDTH-1:0] above_data,
   output logic [DATA_WIDTH-1:0] q
);

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;

   always_comb begin
      unique case (cmd)
         CELL_HOLD: entry_in = entry_ff;
         CELL_LOAD: entry_in = load_data;
         CELL_UP:   entry_in = below_data;
         CELL_DOWN: entry_in = above_data;
         default:   entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

>>> design/ordered_array_list_engine_unit.sv
// Top level of the ordered array list engine: controller and cell chain.
// Depends on oale_pkg, oale_req_if, oale_rsp_if and oale_cell.
//
//   channel  | role   | handshake     | payload
//   req_if   | sink   | valid / ready | req_type, value, position
//   rsp_if   | source | valid / ready | status, data, count, removed
//
// One request is worked on at a time. Append, insert and clear finish in the busy
// state after acceptance, with a registered response. Pop, read and both deletes
// rotate the cell chain once through its stored entries, one entry per cycle,
// before they respond. Reset clears the controller, the entry count and the
// response valid; cell contents are undefined until written.
// A new request is accepted while the previous response still waits in the
// output register; a response that cannot be placed stalls the controller.
module ordered_array_list_engine_unit import oale_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   oale_req_if.sink   req_if,
   oale_rsp_if.source rsp_if
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_BUSY = 1'b1;

   logic state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] kept_ff, kept_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] data_ff, data_in;
   op_type op_ff, op_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [COUNT_W-1:0] rsp_removed_ff, rsp_removed_in;

   logic [DATA_WIDTH-1:0] val_conv;
   logic [DATA_WIDTH-1:0] res_data;
   logic [VALUE_W-1:0] res_data_conv;
   logic [CMP_W-1:0] res_count_x, res_rem_x;
   status_type res_status;
   logic finish, fire, out_free, req_fire;

   logic [CMP_W-1:0] cnt_x, pos_x, left_x, kept_x, rem_x, j_x, wr_x;
   logic head_match, drop;

   cell_cmd_type cell_cmd [DEPTH];
   logic [DATA_WIDTH-1:0] cell_q [DEPTH];
   logic [DATA_WIDTH-1:0] load_data;

   // Value narrowing or sign extension into the stored width; narrowing or zero extension back out.
   generate
      if (DATA_WIDTH <= VALUE_W) begin : g_val_narrow
         assign val_conv = req_if.value[DATA_WIDTH-1:0];
      end else begin : g_val_wide
         assign val_conv = {{(DATA_WIDTH-VALUE_W){req_if.value[VALUE_W-1]}}, req_if.value};
      end
      if (DATA_WIDTH >= VALUE_W) begin : g_out_narrow
         assign res_data_conv = res_data[VALUE_W-1:0];
      end else begin : g_out_wide
         assign res_data_conv = {{(VALUE_W-DATA_WIDTH){1'b0}}, res_data};
      end
   endgenerate

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign cnt_x  = {{(CMP_W-CNT_W){1'b0}}, count_ff};
   assign pos_x  = {{(CMP_W-POS_W){1'b0}}, pos_ff};
   assign left_x = {{(CMP_W-CNT_W){1'b0}}, left_ff};
   assign kept_x = {{(CMP_W-CNT_W){1'b0}}, kept_ff};
   assign rem_x  = {{(CMP_W-CNT_W){1'b0}}, rem_ff};
   // j_x is the original position of the entry now at the head of the chain.
   assign j_x    = cnt_x - left_x;
   // Kept entries are written back just behind the entries not yet scanned.
   assign wr_x   = left_x - CMP_W'(1) + kept_x;
   assign head_match = (cell_q[0] == val_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      left_in     = left_ff;
      kept_in     = kept_ff;
      rem_in      = rem_ff;
      data_in     = data_ff;
      op_in       = op_ff;
      val_in      = val_ff;
      pos_in      = pos_ff;
      finish      = 1'b0;
      drop        = 1'b0;
      res_status  = STAT_OK;
      res_count_x = cnt_x;
      res_rem_x   = '0;
      res_data    = '0;
      load_data   = val_ff;
      for (int k = 0; k < DEPTH; k++) begin
         cell_cmd[k] = CELL_HOLD;
      end

      if (state_ff == S_IDLE) begin
         if (req_fire) begin
            op_in    = req_if.req_type;
            val_in   = val_conv;
            pos_in   = req_if.position;
            left_in  = count_ff;
            kept_in  = '0;
            rem_in   = '0;
            data_in  = '0;
            state_in = S_BUSY;
         end
      end else begin
         unique case (op_ff)
            OP_APPEND: begin
               finish = 1'b1;
               if (cnt_x == CMP_W'(DEPTH)) begin
                  res_status = STAT_FULL;
               end else begin
                  res_count_x = cnt_x + CMP_W'(1);
                  for (int k = 0; k < DEPTH; k++) begin
                     if (CMP_W'(k) == cnt_x) begin
                        cell_cmd[k] = CELL_LOAD;
                     end
                  end
               end
            end
            OP_INSERT: begin
               finish = 1'b1;
               if (cnt_x == CMP_W'(DEPTH)) begin
                  res_status = STAT_FULL;
               end else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
                  res_status = STAT_BADPOS;
               end else begin
                  res_count_x = cnt_x + CMP_W'(1);
                  for (int k = 0; k < DEPTH; k++) begin
                     if (CMP_W'(k) == pos_x - CMP_W'(1)) begin
                        cell_cmd[k] = CELL_LOAD;
                     end else if (CMP_W'(k) > pos_x - CMP_W'(1) && CMP_W'(k) <= cnt_x) begin
                        cell_cmd[k] = CELL_UP;
                     end
                  end
               end
            end
            OP_CLEAR: begin
               finish      = 1'b1;
               res_rem_x   = cnt_x;
               res_count_x = '0;
            end
            OP_POP, OP_READ, OP_DEL_FIRST, OP_DEL_ALL: begin
               if (left_ff == '0) begin
                  finish      = 1'b1;
                  res_count_x = cnt_x - rem_x;
                  res_rem_x   = rem_x;
                  res_data    = data_ff;
                  if (op_ff == OP_POP) begin
                     res_status = (rem_ff == '0) ? STAT_EMPTY : STAT_OK;
                  end else if (op_ff == OP_READ) begin
                     res_status = (pos_x == '0 || pos_x > cnt_x) ? STAT_BADPOS : STAT_OK;
                  end else begin
                     res_status = (rem_ff == '0) ? STAT_NOTFOUND : STAT_OK;
                  end
               end else begin
                  // One rotation step: the head leaves the chain and, unless
                  // it is dropped, comes back in behind the unscanned entries.
                  if (op_ff == OP_POP) begin
                     drop = (j_x == cnt_x - CMP_W'(1));
                  end else if (op_ff == OP_DEL_FIRST) begin
                     drop = head_match && (rem_ff == '0);
                  end else if (op_ff == OP_DEL_ALL) begin
                     drop = head_match;
                  end
                  if ((op_ff == OP_POP && j_x == cnt_x - CMP_W'(1)) ||
                      (op_ff == OP_READ && j_x == pos_x - CMP_W'(1))) begin
                     data_in = cell_q[0];
                  end
                  load_data = cell_q[0];
                  for (int k = 0; k < DEPTH; k++) begin
                     if (!drop && CMP_W'(k) == wr_x) begin
                        cell_cmd[k] = CELL_LOAD;
                     end else begin
                        cell_cmd[k] = CELL_DOWN;
                     end
                  end
                  left_in = left_ff - CNT_W'(1);
                  if (drop) begin
                     rem_in = rem_ff + CNT_W'(1);
                  end else begin
                     kept_in = kept_ff + CNT_W'(1);
                  end
               end
            end
            default: begin
               finish = 1'b1;
            end
         endcase

         // A response that has nowhere to go holds everything in place.
         if (finish && !out_free) begin
            for (int k = 0; k < DEPTH; k++) begin
               cell_cmd[k] = CELL_HOLD;
            end
         end
         if (finish && out_free) begin
            count_in = res_count_x[CNT_W-1:0];
            state_in = S_IDLE;
         end
      end
   end

   assign fire = finish && out_free;

   always_comb begin
      rsp_valid_in   = fire || (rsp_valid_ff && !rsp_if.ready);
      rsp_status_in  = rsp_status_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_removed_in = rsp_removed_ff;
      if (fire) begin
         rsp_status_in  = res_status;
         rsp_data_in    = res_data_conv;
         rsp_count_in   = res_count_x[COUNT_W-1:0];
         rsp_removed_in = res_rem_x[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff        <= left_in;
      kept_ff        <= kept_in;
      rem_ff         <= rem_in;
      data_ff        <= data_in;
      op_ff          <= op_in;
      val_ff         <= val_in;
      pos_ff         <= pos_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.status  = rsp_status_ff;
   assign rsp_if.data    = rsp_data_ff;
   assign rsp_if.count   = rsp_count_ff;
   assign rsp_if.removed = rsp_removed_ff;

   generate
      for (genvar k = 0; k < DEPTH; k++) begin : g_cell
         logic [DATA_WIDTH-1:0] below;
         logic [DATA_WIDTH-1:0] above;
         if (k == 0) begin : g_first
            assign below = '0;
         end else begin : g_inner_lo
            assign below = cell_q[k-1];
         end
         if (k == DEPTH - 1) begin : g_last
            assign above = cell_q[k];
         end else begin : g_inner_hi
            assign above = cell_q[k+1];
         end
         oale_cell #(
            .DATA_WIDTH (DATA_WIDTH)
         ) u_cell (
            .clock      (clock),
            .cmd        (cell_cmd[k]),
            .load_data  (load_data),
            .below_data (below),
            .above_data (above),
            .q          (cell_q[k])
         );
      end
   endgenerate

endmodule
